FILE: rtl/core/sch64_pkg.sv
// shared types and constants for the salted crc-64 name hash
// no dependencies; imported by every module of the block
package sch64_pkg;

    // number of hash bits kept at the top of the crc
    localparam int unsigned HASH_BITS = 28;
    localparam int unsigned CRC_W     = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned APB_AW    = 4;
    localparam int unsigned APB_DW    = 64;

    // reflected ecma-182 polynomial
    localparam logic [CRC_W-1:0] POLY_RESET = 64'hC96C_5795_D787_0F42;

    // keeps the top HASH_BITS bits, clears the rest
    localparam logic [CRC_W-1:0] KEEP_MASK =
        ~((64'd1 << (CRC_W - HASH_BITS)) - 64'd1);

    // register index of the polynomial
    localparam logic REG_POLY = 1'b0;

    // one input item as held in the input stage
    typedef struct packed {
        logic              start_of_name;
        logic [CRC_W-1:0]  salt;
        logic [BYTE_W-1:0] name_byte;
    } t_item;

endpackage

FILE: rtl/core/sch64_apb.sv
// apb-style configuration port holding the crc polynomial
// depends on sch64_pkg
module sch64_apb import sch64_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CRC_W-1:0]  o_poly
);

    logic [CRC_W-1:0] r_poly;
    logic [CRC_W-1:0] n_poly;
    logic             sel_poly;

    // register decode on the 8-byte slot index
    assign sel_poly = (paddr[3] == REG_POLY);

    // write on the access phase of a transfer
    always_comb begin
        n_poly = r_poly;
        if (psel && penable && pwrite && pready && sel_poly) begin
            n_poly = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
        end else begin
            r_poly <= n_poly;
        end
    end

    // read back, unused slots read as zero
    assign prdata = sel_poly ? r_poly : '0;
    assign pready = 1'b1;
    assign o_poly = r_poly;

endmodule

FILE: rtl/core/sch64_core.sv
// input stage, byte-wide crc update and result register
// depends on sch64_pkg
module sch64_core import sch64_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CRC_W-1:0]  i_poly,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_item             i_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CRC_W-1:0]  o_hash_value
);

    // eight shift-and-conditional-xor steps of the reflected crc
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    logic             r_in_valid;
    t_item            r_in;
    logic [CRC_W-1:0] r_crc;
    logic             r_out_valid;
    logic [CRC_W-1:0] r_out_hash;

    logic             n_in_valid;
    t_item            n_in;
    logic [CRC_W-1:0] n_crc;
    logic             n_out_valid;
    logic [CRC_W-1:0] n_out_hash;

    logic             is_term;
    logic             out_free;
    logic             s1_fire;
    logic [CRC_W-1:0] crc_base;
    logic [CRC_W-1:0] crc_next;

    // stage control: a terminator needs room in the result register
    assign is_term    = (r_in.name_byte == '0);
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_in_valid && (!is_term || out_free);
    assign o_in_ready = !r_in_valid || s1_fire;

    // crc datapath
    assign crc_base = r_in.start_of_name ? r_in.salt : r_crc;
    assign crc_next = crc_byte(crc_base, r_in.name_byte, i_poly);

    // next-state logic
    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_out_hash  = r_out_hash;

        // input register
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
            n_in       = i_item;
        end

        // running crc and result register
        if (out_free) begin
            n_out_valid = 1'b0;
        end
        if (s1_fire) begin
            if (is_term) begin
                n_crc       = crc_base;
                n_out_valid = 1'b1;
                n_out_hash  = crc_base & KEEP_MASK;
            end else begin
                n_crc = crc_next;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_crc       <= n_crc;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_out_hash <= n_out_hash;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

`ifndef ASSERT_OFF
    // low bits of a result are always cleared
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_hash & ~KEEP_MASK) == '0))
        else $error("hash result has bits below the kept field");

    // a processed terminator always produces a result
    a_term_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && is_term) |=> r_out_valid)
        else $error("terminator did not produce a result");

    // running crc only moves when the input stage is processed
    a_crc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_fire && $past(i_rst_n)) |=> $stable(r_crc))
        else $error("running crc changed without a processed byte");

    // a nonzero byte never replaces a waiting result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !(s1_fire && is_term)) |=>
        (r_out_valid && $stable(r_out_hash)))
        else $error("waiting result was overwritten");
`endif

endmodule

FILE: rtl/core/salted_crc64_name_hash_top.sv
// top level of the salted crc-64 name hash
// depends on sch64_pkg, sch64_apb and sch64_core
//
//  port group   direction  handshake                      payload
//  in           to block   i_in_valid / o_in_ready        start_of_name, salt, name_byte
//  out          from block o_out_valid / i_out_ready      hash_value
//  config       to block   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one byte is taken every cycle unless a terminator waits on a stalled result; each
// result passes the input register, the byte-wide crc logic and the result register.
// a zero byte emits one result; other bytes emit none.
// reset is synchronous and active low; it clears the running crc and loads the
// reflected ecma-182 polynomial.
// a stalled result only blocks input when the next byte in the input register is a
// terminator; nonzero bytes keep flowing.
module salted_crc64_name_hash_top import sch64_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_start_of_name,
    input  logic [CRC_W-1:0]  i_salt,
    input  logic [BYTE_W-1:0] i_name_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CRC_W-1:0]  o_hash_value
);

    logic [CRC_W-1:0] poly;
    t_item            in_item;

    // pack the input transfer
    assign in_item = '{start_of_name: i_start_of_name, salt: i_salt,
                       name_byte: i_name_byte};

    sch64_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_poly  (poly)
    );

    sch64_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poly       (poly),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (in_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hash_value (o_hash_value)
    );

endmodule
